@@ hdl/elr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package elr_pkg;

    localparam int SIZE_W  = 7;
    localparam int TYPE_W  = 6;
    localparam int STAMP_W = 32;
    localparam int TOTAL_W = 32;
    localparam int MASK_W  = 32;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_START  = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_RESET  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_GLOBAL_ENABLE = 2'd0,
        CFG_TYPE_MASK     = 2'd1,
        CFG_SLOTS         = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  etype;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic               done;
        logic [SIZE_W-1:0]  left;
        logic [TOTAL_W-1:0] total;
        logic               recorded;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/elr_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module elr_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_addr,
    input  wire elr_pkg::entry_t       wr_data,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output elr_pkg::entry_t            rd_data,
    output logic                       busy
);
    import elr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic             clr_active_reg;
    logic             clr_active_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            if (clr_idx_reg == IDX_W'(DEPTH - 1))
                clr_active_next = 1'b0;
            else
                clr_idx_next = clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    // zero one entry per cycle after reset, then take normal writes
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            mem[clr_idx_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

`default_nettype wire

@@ hdl/elr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module elr_ctrl #(
    parameter int DEPTH     = 64,
    parameter int NUM_TYPES = 32,
    parameter int IDX_W     = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [elr_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       fire,
    input  wire logic [1:0]                 req_type,
    input  wire logic [elr_pkg::TYPE_W-1:0] event_type,
    input  wire logic [elr_pkg::STAMP_W-1:0] stamp,
    output logic                            wr_en,
    output logic [IDX_W-1:0]                wr_addr,
    output elr_pkg::entry_t                 wr_data,
    output logic [IDX_W-1:0]                rd_addr,
    output elr_pkg::result_t                res
);
    import elr_pkg::*;

    localparam int CMP_W = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;

    logic               global_en_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [SIZE_W-1:0]  slots_reg;

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [IDX_W-1:0]   write_slot_reg;
    logic [IDX_W-1:0]   write_slot_next;
    logic [IDX_W-1:0]   read_slot_reg;
    logic [IDX_W-1:0]   read_slot_next;
    logic [SIZE_W-1:0]  visits_reg;
    logic [SIZE_W-1:0]  visits_next;

    logic [SIZE_W-1:0]  size;
    logic [IDX_W-1:0]   wslot;
    logic [IDX_W-1:0]   rslot;
    logic               type_ok;
    logic               recorded;

    function automatic logic [IDX_W-1:0] fix_idx(
        input logic [IDX_W-1:0]  idx,
        input logic [SIZE_W-1:0] sz
    );
        return (CMP_W'(idx) >= CMP_W'(sz)) ? '0 : idx;
    endfunction

    function automatic logic [IDX_W-1:0] dec_idx(
        input logic [IDX_W-1:0]  idx,
        input logic [SIZE_W-1:0] sz
    );
        return (idx == '0) ? IDX_W'(sz - SIZE_W'(1)) : idx - 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_en_reg <= 1'b1;
            mask_reg      <= '1;
            slots_reg     <= SIZE_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLOBAL_ENABLE: global_en_reg <= cfg_data[0];
                CFG_TYPE_MASK:     mask_reg      <= cfg_data[MASK_W-1:0];
                CFG_SLOTS:         slots_reg     <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (slots_reg == '0)
            size = SIZE_W'(1);
        else if (int'(slots_reg) > DEPTH)
            size = SIZE_W'(DEPTH);
        else
            size = slots_reg;
    end

    assign wslot = fix_idx(write_slot_reg, size);
    assign rslot = fix_idx(read_slot_reg, size);

    always_comb
    begin
        type_ok = 1'b0;
        if (event_type != '0 && {1'b0, event_type} <= 7'(NUM_TYPES)
            && event_type <= TYPE_W'(32))
            type_ok = mask_reg[5'(event_type - TYPE_W'(1))];
    end

    always_comb
    begin
        total_next      = total_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        visits_next     = visits_reg;
        recorded        = 1'b0;
        case (req_type)
            REQ_RECORD:
            begin
                if (global_en_reg && type_ok)
                begin
                    recorded   = 1'b1;
                    total_next = total_reg + 1'b1;
                    if (CMP_W'(wslot) + CMP_W'(1) >= CMP_W'(size))
                        write_slot_next = '0;
                    else
                        write_slot_next = wslot + 1'b1;
                end
            end
            REQ_START:
            begin
                if (total_reg == '0)
                begin
                    read_slot_next = '0;
                    visits_next    = '0;
                end
                else
                begin
                    read_slot_next = dec_idx(wslot, size);
                    visits_next    = (total_reg >= TOTAL_W'(size))
                                   ? size : total_reg[SIZE_W-1:0];
                end
            end
            REQ_STEP:
            begin
                if (visits_reg != '0)
                begin
                    visits_next    = visits_reg - 1'b1;
                    read_slot_next = dec_idx(rslot, size);
                end
            end
            default:
            begin
                read_slot_next = '0;
                visits_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            visits_reg     <= '0;
        end
        else if (fire)
        begin
            total_reg      <= total_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            visits_reg     <= visits_next;
        end
    end

    assign wr_en         = fire && recorded;
    assign wr_addr       = wslot;
    assign wr_data.etype = event_type;
    assign wr_data.stamp = stamp;
    assign rd_addr       = fix_idx(read_slot_next, size);

    assign res.done     = (visits_next == '0);
    assign res.left     = visits_next;
    assign res.total    = total_next;
    assign res.recorded = recorded;

    a_total_bump: assert property (@(posedge clk) disable iff (!rst_n)
        fire && recorded |=> total_reg == $past(total_reg) + 32'd1)
        else $error("event count did not advance on a stored item");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(total_reg) && $stable(write_slot_reg)
                  && $stable(read_slot_reg) && $stable(visits_reg))
        else $error("log state moved without an item");

    a_write_only_record: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> req_type == REQ_RECORD && global_en_reg)
        else $error("store written by a request that does not record");

endmodule

`default_nettype wire

@@ hdl/event_log_ring_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Event log ring buffer. One request item is taken per clock cycle while
// in_stall is low; each result passes the input register, then the result
// register that also captures the registered store read, and results leave
// in request order. The two-stage pipeline lets one new item enter while a
// result waits under out_stall. After reset the store is zeroed by a sweep
// over all DEPTH entries, one entry per cycle, during which in_stall stays
// high; configuration writes are taken at any time (cfg_ready is always
// high) but are meant to happen only while no request is in flight.
// entry_type and entry_time read zero whenever iteration_done is set.
module event_log_ring_buffer #(
    parameter int DEPTH     = 64,
    parameter int NUM_TYPES = 32,
    parameter int TIME_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [elr_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   req_type,
    input  wire logic [elr_pkg::TYPE_W-1:0]   event_type,
    input  wire logic [TIME_BITS-1:0]         time_stamp,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [elr_pkg::TYPE_W-1:0]        entry_type,
    output logic [TIME_BITS-1:0]              entry_time,
    output logic                              iteration_done,
    output logic [elr_pkg::SIZE_W-1:0]        entries_left,
    output logic [elr_pkg::TOTAL_W-1:0]       events_seen,
    output logic                              was_recorded
);
    import elr_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [1:0]         s1_req_reg;
    logic [TYPE_W-1:0]  s1_type_reg;
    logic [STAMP_W-1:0] s1_stamp_reg;

    logic               s2_valid_reg;
    logic               s2_valid_next;
    result_t            s2_res_reg;
    logic               s2_bypass_reg;
    entry_t             s2_wdata_reg;

    logic               in_accept;
    logic               s2_free;
    logic               fire;
    logic               busy;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;
    entry_t             entry;
    result_t            res;

    assign s2_free   = !s2_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && s2_free;
    assign in_stall  = busy || (s1_valid_reg && !s2_free);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (fire)
            s2_valid_next = 1'b1;
        else if (!out_stall)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg   <= req_type;
            s1_type_reg  <= event_type;
            s1_stamp_reg <= STAMP_W'(time_stamp);
        end
    end

    // forward the write when it lands on the entry being read
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s2_res_reg    <= res;
            s2_bypass_reg <= wr_en && (wr_addr == rd_addr);
            s2_wdata_reg  <= wr_data;
        end
    end

    elr_ctrl #(
        .DEPTH     (DEPTH),
        .NUM_TYPES (NUM_TYPES),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (fire),
        .req_type   (s1_req_reg),
        .event_type (s1_type_reg),
        .stamp      (s1_stamp_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .res        (res)
    );

    elr_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (busy)
    );

    assign entry = s2_bypass_reg ? s2_wdata_reg : rd_data;

    assign out_valid      = s2_valid_reg;
    assign entry_type     = s2_res_reg.done ? '0 : entry.etype;
    assign entry_time     = s2_res_reg.done ? '0 : TIME_BITS'(entry.stamp);
    assign iteration_done = s2_res_reg.done;
    assign entries_left   = s2_res_reg.left;
    assign events_seen    = s2_res_reg.total;
    assign was_recorded   = s2_res_reg.recorded;

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("advanced item did not reach the result register");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !fire |=> s1_valid_reg)
        else $error("waiting item dropped from the input register");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s1_valid_reg && !s2_valid_reg)
        else $error("item in flight during the clearing sweep");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import elr_pkg::*;

    localparam int LOG_DEPTH = 64;
    localparam int LOG_TYPES = 32;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 190;
    localparam logic [1:0] CFG_NO_REG = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]  etype;
        logic [STAMP_W-1:0] stamp;
        logic               done;
        logic [SIZE_W-1:0]  left;
        logic [TOTAL_W-1:0] total;
        logic               recorded;
    } log_result_t;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        req_t               rq;
        logic [TYPE_W-1:0]  et;
        logic [STAMP_W-1:0] ts;
        logic [1:0]         reg_idx;
        logic [CFG_W-1:0]   reg_val;
        bit                 fixed;
        log_result_t        want;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = '0;
    logic [TYPE_W-1:0]  event_type = '0;
    logic [STAMP_W-1:0] time_stamp = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [TYPE_W-1:0]  entry_type;
    logic [STAMP_W-1:0] entry_time;
    logic               iteration_done;
    logic [SIZE_W-1:0]  entries_left;
    logic [TOTAL_W-1:0] events_seen;
    logic               was_recorded;

    // shadow of the log contents, pointers and registers
    logic [TYPE_W-1:0]  log_type [LOG_DEPTH];
    logic [STAMP_W-1:0] log_stamp [LOG_DEPTH];
    logic [TOTAL_W-1:0] log_count;
    int                 wr_pos;
    int                 rd_pos;
    int                 to_visit;
    logic               rec_enable;
    logic [MASK_W-1:0]  rec_mask;
    logic [SIZE_W-1:0]  slot_cfg;

    log_result_t        readouts_due [$];
    script_row_t        script [$];
    int                 mismatches = 0;
    int                 sent_count = 0;

    // typed expectation for the item currently offered
    bit                 row_fixed = 1'b0;
    log_result_t        row_want = '0;

    bit                 src_idle = 1'b1;
    int                 src_quiet = 0;
    bit                 sink_idle = 1'b1;
    int                 sink_hold = 0;

    event_log_ring_buffer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .event_type     (event_type),
        .time_stamp     (time_stamp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_type     (entry_type),
        .entry_time     (entry_time),
        .iteration_done (iteration_done),
        .entries_left   (entries_left),
        .events_seen    (events_seen),
        .was_recorded   (was_recorded)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int eff_slots();
        if (slot_cfg == 0)
            return 1;
        if (slot_cfg > LOG_DEPTH)
            return LOG_DEPTH;
        return int'(slot_cfg);
    endfunction

    function automatic void clear_log();
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            log_type[i] = '0;
            log_stamp[i] = '0;
        end
        log_count = '0;
        wr_pos = 0;
        rd_pos = 0;
        to_visit = 0;
        rec_enable = 1'b1;
        rec_mask = '1;
        slot_cfg = 7'd64;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_GLOBAL_ENABLE: rec_enable = val[0];
            CFG_TYPE_MASK:     rec_mask = val;
            CFG_SLOTS:         slot_cfg = val[SIZE_W-1:0];
            default:           ;
        endcase
    endfunction

    // apply one request to the shadow log and return what the read side shows
    function automatic log_result_t log_readout(req_t rq, logic [TYPE_W-1:0] et,
                                                logic [STAMP_W-1:0] ts);
        log_result_t res;
        int size;
        int pos;
        size = eff_slots();
        res = '0;
        case (rq)
            REQ_RECORD:
            begin
                if (rec_enable && et >= 1 && et <= LOG_TYPES && rec_mask[et - 6'd1])
                begin
                    pos = (wr_pos >= size) ? 0 : wr_pos;
                    log_type[pos] = et;
                    log_stamp[pos] = ts;
                    wr_pos = (pos + 1 >= size) ? 0 : pos + 1;
                    log_count = log_count + 1'b1;
                    res.recorded = 1'b1;
                end
            end
            REQ_START:
            begin
                if (log_count == 0)
                begin
                    rd_pos = 0;
                    to_visit = 0;
                end
                else
                begin
                    pos = (wr_pos >= size) ? 0 : wr_pos;
                    rd_pos = (pos == 0) ? size - 1 : pos - 1;
                    to_visit = (log_count >= 32'(size)) ? size : int'(log_count);
                end
            end
            REQ_STEP:
            begin
                if (to_visit > 0)
                begin
                    to_visit = to_visit - 1;
                    pos = (rd_pos >= size) ? 0 : rd_pos;
                    rd_pos = (pos == 0) ? size - 1 : pos - 1;
                end
            end
            default:
            begin
                rd_pos = 0;
                to_visit = 0;
            end
        endcase
        if (to_visit == 0)
        begin
            res.done = 1'b1;
        end
        else
        begin
            pos = (rd_pos >= size) ? 0 : rd_pos;
            res.etype = log_type[pos];
            res.stamp = log_stamp[pos];
        end
        res.left = SIZE_W'(to_visit);
        res.total = log_count;
        return res;
    endfunction

    task automatic flag_result(input string what, input log_result_t got,
                               input log_result_t want);
        if (mismatches < 10)
        begin
            $display("%0t: %s: got type %0d stamp %h done %0b left %0d seen %0d rec %0b",
                     $time, what, got.etype, got.stamp, got.done, got.left, got.total,
                     got.recorded);
            $display("    want type %0d stamp %h done %0b left %0d seen %0d rec %0b",
                     want.etype, want.stamp, want.done, want.left, want.total,
                     want.recorded);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        log_result_t got;
        log_result_t want;
        if (rst_n)
        begin
            // retire the oldest expectation before adding a new one
            if (out_valid && !out_stall)
            begin
                got = '{entry_type, entry_time, iteration_done, entries_left,
                        events_seen, was_recorded};
                if (readouts_due.size() == 0)
                begin
                    flag_result("unexpected result", got, '0);
                end
                else
                begin
                    want = readouts_due.pop_front();
                    if (got.etype !== want.etype || got.stamp !== want.stamp
                        || got.done !== want.done || got.left !== want.left
                        || got.total !== want.total || got.recorded !== want.recorded)
                        flag_result("result mismatch", got, want);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = log_readout(req_t'(req_type), event_type, time_stamp);
                if (row_fixed)
                    want = row_want;
                readouts_due.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    initial
    begin : sink_drive
        int run_left;
        bit run_stall;
        run_left = 0;
        run_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                out_stall <= 1'b1;
                sink_hold = sink_hold - 1;
            end
            else if (sink_idle)
            begin
                if (run_left == 0)
                begin
                    run_stall = ($urandom_range(0, 2) == 0);
                    run_left = $urandom_range(1, 16);
                end
                out_stall <= run_stall;
                run_left = run_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        if (!src_idle)
            return 0;
        if (src_quiet > 0)
        begin
            src_quiet = src_quiet - 1;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            src_quiet = $urandom_range(20, 60);
            return 0;
        end
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    task automatic offer_request(input req_t rq, input logic [TYPE_W-1:0] et,
                                 input logic [STAMP_W-1:0] ts, input bit fixed,
                                 input log_result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rq;
        event_type <= et;
        time_stamp <= ts;
        row_fixed = fixed;
        row_want = want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (readouts_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TYPE_W-1:0] pick_type();
        if ($urandom_range(0, 6) == 0)
            return TYPE_W'($urandom_range(0, 63));
        return TYPE_W'($urandom_range(1, LOG_TYPES));
    endfunction

    function automatic log_result_t view(logic [TYPE_W-1:0] xt, logic [STAMP_W-1:0] xs,
                                         logic dn, int lf, logic [TOTAL_W-1:0] tot,
                                         logic rc);
        return '{xt, xs, dn, SIZE_W'(lf), tot, rc};
    endfunction

    function automatic void add_fixed(req_t rq, logic [TYPE_W-1:0] et,
                                      logic [STAMP_W-1:0] ts, log_result_t want);
        script.push_back('{ROW_REQ, rq, et, ts, 2'd0, '0, 1'b1, want});
    endfunction

    function automatic void add_req(req_t rq, logic [TYPE_W-1:0] et,
                                    logic [STAMP_W-1:0] ts);
        script.push_back('{ROW_REQ, rq, et, ts, 2'd0, '0, 1'b0, '0});
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [CFG_W-1:0] val);
        script.push_back('{ROW_CFG, REQ_RECORD, '0, '0, idx, val, 1'b0, '0});
    endfunction

    initial
    begin
        script_row_t row;
        int phase_start;
        int pick;
        int n;
        logic [CFG_W-1:0] word;
        logic en_val;
        logic [MASK_W-1:0] mask_val;
        logic [SIZE_W-1:0] slots_val;

        clear_log();

        // empty log, then the type range edges
        add_fixed(REQ_STEP, 6'd0, 32'h0, view(0, 0, 1, 0, 0, 0));
        add_fixed(REQ_START, 6'd0, 32'h0, view(0, 0, 1, 0, 0, 0));
        add_fixed(REQ_RECORD, 6'd1, 32'h0, view(0, 0, 1, 0, 1, 1));
        add_fixed(REQ_RECORD, 6'd32, 32'hFFFF_FFFF, view(0, 0, 1, 0, 2, 1));
        add_fixed(REQ_RECORD, 6'd0, 32'h1234_5678, view(0, 0, 1, 0, 2, 0));
        add_fixed(REQ_RECORD, 6'd33, 32'h8765_4321, view(0, 0, 1, 0, 2, 0));
        add_fixed(REQ_RECORD, 6'd63, 32'hFFFF_FFFF, view(0, 0, 1, 0, 2, 0));
        add_fixed(REQ_START, 6'd17, 32'h0, view(32, 32'hFFFF_FFFF, 0, 2, 2, 0));
        add_fixed(REQ_STEP, 6'd0, 32'h0, view(1, 0, 0, 1, 2, 0));
        add_fixed(REQ_STEP, 6'd0, 32'h0, view(0, 0, 1, 0, 2, 0));
        // step past the oldest entry: nothing moves
        add_fixed(REQ_STEP, 6'd63, 32'hFFFF_FFFF, view(0, 0, 1, 0, 2, 0));
        add_req(REQ_START, 6'd0, 32'h0);
        add_fixed(REQ_RESET, 6'd63, 32'hFFFF_FFFF, view(0, 0, 1, 0, 2, 0));
        add_write(CFG_GLOBAL_ENABLE, 32'hFFFF_FFFE);
        add_fixed(REQ_RECORD, 6'd5, 32'hAAAA_5555, view(0, 0, 1, 0, 2, 0));
        add_write(CFG_GLOBAL_ENABLE, 32'h0000_0001);
        add_write(CFG_TYPE_MASK, 32'h0000_0010);
        add_fixed(REQ_RECORD, 6'd6, 32'h0F0F_F0F0, view(0, 0, 1, 0, 2, 0));
        add_fixed(REQ_RECORD, 6'd5, 32'h5555_AAAA, view(0, 0, 1, 0, 3, 1));
        add_write(CFG_TYPE_MASK, 32'hFFFF_FFFF);
        // zero size acts as one entry; write index falls back to zero
        add_write(CFG_SLOTS, 32'h0000_0000);
        add_req(REQ_RECORD, 6'd7, 32'h0000_0001);
        add_req(REQ_RECORD, 6'd8, 32'h0000_0002);
        add_req(REQ_START, 6'd0, 32'h0);
        add_req(REQ_STEP, 6'd0, 32'h0);
        // oversize clamps to the full depth
        add_write(CFG_SLOTS, 32'd100);
        add_req(REQ_START, 6'd0, 32'h0);
        add_req(REQ_STEP, 6'd0, 32'h0);
        // shrink below the read pointer mid iteration
        add_write(CFG_SLOTS, 32'd3);
        add_req(REQ_STEP, 6'd0, 32'h0);
        add_req(REQ_RECORD, 6'd31, 32'hDEAD_BEEF);
        add_req(REQ_START, 6'd0, 32'h0);
        add_req(REQ_STEP, 6'd0, 32'h0);
        add_write(CFG_NO_REG, 32'h0000_0000);
        add_write(CFG_SLOTS, 32'd64);
        add_req(REQ_START, 6'd0, 32'h0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_CFG)
                write_register(row.reg_idx, row.reg_val);
            else
                offer_request(row.rq, row.et, row.ts, row.fixed, row.want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            en_val = 1'b1;
            mask_val = '1;
            case (ph)
                0: slots_val = 7'd64;
                1: slots_val = 7'd1;
                2:
                begin
                    slots_val = 7'd2;
                    mask_val = $urandom();
                end
                3: slots_val = 7'd0;
                4: slots_val = 7'd64;
                5:
                begin
                    slots_val = 7'd127;
                    en_val = 1'b0;
                end
                6:
                begin
                    slots_val = SIZE_W'($urandom_range(1, LOG_DEPTH));
                    mask_val = $urandom();
                end
                7:
                begin
                    slots_val = 7'd5;
                    mask_val = 32'h1 << $urandom_range(0, 31);
                end
                8:
                begin
                    slots_val = 7'd3;
                    mask_val = '0;
                end
                default:
                begin
                    slots_val = SIZE_W'($urandom_range(1, LOG_DEPTH));
                    mask_val = $urandom();
                end
            endcase
            word = $urandom();
            word[0] = en_val;
            write_register(CFG_GLOBAL_ENABLE, word);
            write_register(CFG_TYPE_MASK, mask_val);
            word = $urandom();
            word[SIZE_W-1:0] = slots_val;
            write_register(CFG_SLOTS, word);

            @(posedge clk);
            src_idle = (ph != 4 && ph != PHASES - 1);
            sink_idle = (ph != PHASES - 1);
            // hold the output long enough for the pipeline to back up
            if (ph == 4)
                sink_hold = 80;

            phase_start = sent_count;
            while (sent_count - phase_start < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                begin
                    n = $urandom_range(1, 2 * eff_slots() + 2);
                    if (n > 70)
                        n = 70;
                    repeat (n) offer_request(REQ_RECORD, pick_type(), $urandom(), 1'b0, '0);
                end
                else if (pick < 14)
                begin
                    offer_request(REQ_START, TYPE_W'($urandom()), $urandom(), 1'b0, '0);
                    n = $urandom_range(1, eff_slots() + 2);
                    repeat (n) offer_request(REQ_STEP, TYPE_W'($urandom()), $urandom(),
                                             1'b0, '0);
                    if ($urandom_range(0, 3) == 0)
                        offer_request(REQ_RESET, TYPE_W'($urandom()), $urandom(), 1'b0, '0);
                end
                else if (pick < 19)
                begin
                    repeat ($urandom_range(1, 8))
                        offer_request(req_t'($urandom_range(0, 3)), TYPE_W'($urandom()),
                                      $urandom(), 1'b0, '0);
                end
                else if (src_idle)
                begin
                    settle();
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
